### hw/rtl/vp8d_pkg.sv
// ---------------------------------------------------------------------------
// VP8 RTP depacketizer package
// Shared widths, descriptor bit masks and the result word type used by the
// parser, the result queue and the top level.
// ---------------------------------------------------------------------------
package vp8d_pkg;

   // Field widths.
   localparam int ByteWidth = 8;
   localparam int TsWidth   = 32;

   // Default depth of the queue between the parser and the result port.
   localparam int QueueDepthDefault = 4;

   // Bits of the first descriptor byte.
   localparam int DescXBit = 7;
   localparam int DescSBit = 4;

   // Bits of the extension byte.
   localparam int ExtIBit = 7;
   localparam int ExtLBit = 6;
   localparam int ExtTBit = 5;
   localparam int ExtKBit = 4;

   // Bit of the first picture id byte that selects the two-byte form.
   localparam int PicMBit = 7;

   // Bit of the first payload byte that is 0 on a keyframe.
   localparam int PayloadPBit = 0;

   // One result word.
   typedef struct packed {
      logic [ByteWidth-1:0] out_byte;
      logic                 byte_valid;
      logic                 start_of_gop;
      logic                 frame_end;
      logic                 frame_keyframe;
      logic [TsWidth-1:0]   frame_timestamp;
   } result_type;

endpackage

### hw/rtl/vp8d_parse.sv
// ---------------------------------------------------------------------------
// VP8 RTP descriptor parser
// Front part: walks the payload descriptor of each packet one byte at a time,
// drops descriptor bytes, and builds a result word for payload bytes and for
// the byte that closes a marked frame.
// ---------------------------------------------------------------------------
module vp8d_parse (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_fire,
   input  logic [vp8d_pkg::ByteWidth-1:0]    data_byte,
   input  logic                              packet_first,
   input  logic                              packet_last,
   input  logic                              marker,
   input  logic [vp8d_pkg::TsWidth-1:0]      timestamp_ms,
   output logic                              res_valid,
   output vp8d_pkg::result_type              res_word
);

   // Descriptor walk phases.
   typedef enum logic [2:0] {
      PH_DESC,
      PH_EXT,
      PH_PIC1,
      PH_PIC2,
      PH_TL0,
      PH_TK,
      PH_DATA
   } phase_type;

   // Pending extension fields: bit 0 picture id, bit 1 TL0PICIDX,
   // bit 2 TID/KEYIDX.
   localparam int FlI  = 0;
   localparam int FlL  = 1;
   localparam int FlTk = 2;

   phase_type                      phase_ff, phase_in, phase_cur;
   logic                           pstart_ff, pstart_in;
   logic [2:0]                     flags_ff, flags_in;
   logic                           pend_ff, pend_in;
   logic                           key_ff, key_in;
   logic [vp8d_pkg::TsWidth-1:0]   ts_ff, ts_in;
   logic                           valid_c, gop_c, fend_c;

   // Next field to skip, in descriptor order.
   function automatic phase_type next_phase(input logic [2:0] flags);
      phase_type ph;
      if (flags[FlI]) begin
         ph = PH_PIC1;
      end else if (flags[FlL]) begin
         ph = PH_TL0;
      end else if (flags[FlTk]) begin
         ph = PH_TK;
      end else begin
         ph = PH_DATA;
      end
      return ph;
   endfunction

   // Per-byte state update and result build.
   always_comb begin
      phase_cur = packet_first ? PH_DESC : phase_ff;
      phase_in  = phase_cur;
      pstart_in = pstart_ff;
      flags_in  = flags_ff;
      pend_in   = pend_ff;
      key_in    = key_ff;
      ts_in     = ts_ff;
      valid_c   = 1'b0;
      gop_c     = 1'b0;
      fend_c    = 1'b0;

      unique case (phase_cur)
         PH_EXT: begin
            flags_in[FlI]  = data_byte[vp8d_pkg::ExtIBit];
            flags_in[FlL]  = data_byte[vp8d_pkg::ExtLBit];
            flags_in[FlTk] = data_byte[vp8d_pkg::ExtTBit] | data_byte[vp8d_pkg::ExtKBit];
            phase_in       = next_phase(flags_in);
         end
         PH_PIC1: begin
            if (data_byte[vp8d_pkg::PicMBit]) begin
               phase_in = PH_PIC2;
            end else begin
               flags_in[FlI] = 1'b0;
               phase_in      = next_phase(flags_in);
            end
         end
         PH_PIC2: begin
            flags_in[FlI] = 1'b0;
            phase_in      = next_phase(flags_in);
         end
         PH_TL0: begin
            flags_in[FlL] = 1'b0;
            phase_in      = next_phase(flags_in);
         end
         PH_TK: begin
            flags_in[FlTk] = 1'b0;
            phase_in       = next_phase(flags_in);
         end
         PH_DATA: begin
            valid_c = 1'b1;
            if (pend_ff) begin
               pend_in = 1'b0;
               if (pstart_ff) begin
                  ts_in = timestamp_ms;
                  if (!data_byte[vp8d_pkg::PayloadPBit]) begin
                     key_in = 1'b1;
                     gop_c  = 1'b1;
                  end
               end
            end
         end
         default: begin
            // First descriptor byte; an unused phase code also restarts here.
            pstart_in = data_byte[vp8d_pkg::DescSBit];
            flags_in  = '0;
            pend_in   = 1'b1;
            phase_in  = data_byte[vp8d_pkg::DescXBit] ? PH_EXT : PH_DATA;
         end
      endcase

      // End of packet: a packet with no payload still captures the timestamp if S is set.
      if (packet_last) begin
         if (pend_in && pstart_in) begin
            ts_in = timestamp_ms;
         end
         pend_in  = 1'b0;
         phase_in = PH_DESC;
         fend_c   = marker;
      end

      res_valid                = valid_c | fend_c;
      res_word.out_byte        = valid_c ? data_byte : '0;
      res_word.byte_valid      = valid_c;
      res_word.start_of_gop    = gop_c;
      res_word.frame_end       = fend_c;
      res_word.frame_keyframe  = key_in;
      res_word.frame_timestamp = ts_in;

      // A closed frame starts over.
      if (fend_c) begin
         key_in = 1'b0;
         ts_in  = '0;
      end
   end

   // Parser state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_DESC;
         pstart_ff <= 1'b0;
         flags_ff  <= '0;
         pend_ff   <= 1'b0;
         key_ff    <= 1'b0;
         ts_ff     <= '0;
      end else if (in_fire) begin
         phase_ff  <= phase_in;
         pstart_ff <= pstart_in;
         flags_ff  <= flags_in;
         pend_ff   <= pend_in;
         key_ff    <= key_in;
         ts_ff     <= ts_in;
      end
   end

`ifndef SYNTH
   // A start of GOP is always a payload byte of a keyframe.
   a_gop_is_key: assert property (@(posedge clock) disable iff (reset)
      (in_fire && res_valid && res_word.start_of_gop) |->
         (res_word.byte_valid && res_word.frame_keyframe))
      else $error("start of GOP without keyframe payload byte");

   // A result that carries no byte must close a frame.
   a_empty_is_end: assert property (@(posedge clock) disable iff (reset)
      (res_valid && !res_word.byte_valid) |-> res_word.frame_end)
      else $error("result word without byte or frame end");

   // Closing a frame clears the sticky flag and timestamp.
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (in_fire && res_valid && res_word.frame_end) |=> (!key_ff && ts_ff == '0))
      else $error("frame state not cleared after frame end");
`endif

endmodule

### hw/rtl/vp8d_queue.sv
// ---------------------------------------------------------------------------
// VP8 RTP depacketizer result queue
// Back part: holds result words between the parser and the result port so
// that either side can stall on its own.
// ---------------------------------------------------------------------------
module vp8d_queue #(
   parameter int Depth = vp8d_pkg::QueueDepthDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  vp8d_pkg::result_type  push_word,
   output logic                  full,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output vp8d_pkg::result_type  pop_word
);

   localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountWidth = $clog2(Depth + 1);

   vp8d_pkg::result_type      mem_ff [Depth];
   logic [PtrWidth-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]     count_ff, count_in;
   logic                      pop;

   assign pop       = pop_valid & pop_ready;
   assign pop_valid = (count_ff != '0);
   assign full      = (count_ff == CountWidth'(Depth));
   assign pop_word  = mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Word storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

`ifndef SYNTH
   // The parser never writes into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

   // The fill count stays within the depth.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(Depth))
      else $error("queue count beyond depth");

   // A lone pop lowers the count by one.
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue count not lowered by pop");
`endif

endmodule

### hw/rtl/vp8_rtp_depacketizer_core.sv
// ---------------------------------------------------------------------------
// VP8 RTP depacketizer core
// Strips the VP8 payload descriptor from RTP payload bytes, passes payload
// bytes through and reports keyframe, start of GOP and frame end.
// ---------------------------------------------------------------------------
// The block takes one payload word per clock cycle while req_ready is high, and
// a result word is pushed into the queue when its input word is accepted. The
// descriptor parser updates its state once per accepted word, which sets that
// rate. Words that cause no result (descriptor bytes that do not close a frame)
// are dropped. A queue of QueueDepth result words lets the input keep flowing
// while the result side stalls; req_ready falls only when that queue is full.
module vp8_rtp_depacketizer_core #(
   parameter int QueueDepth = vp8d_pkg::QueueDepthDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [vp8d_pkg::ByteWidth-1:0]    req_data_byte,
   input  logic                              req_packet_first,
   input  logic                              req_packet_last,
   input  logic                              req_marker,
   input  logic [vp8d_pkg::TsWidth-1:0]      req_timestamp_ms,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [vp8d_pkg::ByteWidth-1:0]    rsp_out_byte,
   output logic                              rsp_byte_valid,
   output logic                              rsp_start_of_gop,
   output logic                              rsp_frame_end,
   output logic                              rsp_frame_keyframe,
   output logic [vp8d_pkg::TsWidth-1:0]      rsp_frame_timestamp
);

   logic                  in_fire;
   logic                  res_valid;
   logic                  queue_full;
   vp8d_pkg::result_type  res_word;
   vp8d_pkg::result_type  out_word;

   assign req_ready = ~queue_full;
   assign in_fire   = req_valid & req_ready;

   // Front: descriptor parser.
   vp8d_parse u_parse (
      .clock        (clock),
      .reset        (reset),
      .in_fire      (in_fire),
      .data_byte    (req_data_byte),
      .packet_first (req_packet_first),
      .packet_last  (req_packet_last),
      .marker       (req_marker),
      .timestamp_ms (req_timestamp_ms),
      .res_valid    (res_valid),
      .res_word     (res_word)
   );

   // Back: result queue feeding the result port.
   vp8d_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (in_fire & res_valid),
      .push_word (res_word),
      .full      (queue_full),
      .pop_valid (rsp_valid),
      .pop_ready (rsp_ready),
      .pop_word  (out_word)
   );

   assign rsp_out_byte        = out_word.out_byte;
   assign rsp_byte_valid      = out_word.byte_valid;
   assign rsp_start_of_gop    = out_word.start_of_gop;
   assign rsp_frame_end       = out_word.frame_end;
   assign rsp_frame_keyframe  = out_word.frame_keyframe;
   assign rsp_frame_timestamp = out_word.frame_timestamp;

endmodule

### test/vp8_rtp_depacketizer_core_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// VP8 RTP depacketizer core testbench
// Sends RTP payload words into the core, mostly as well-formed packets with
// random descriptor and payload content, plus broken packets and noise.
// A cycle-free model of the descriptor parser predicts every result word, and
// each result is checked field by field. Both sides idle at random.
// ---------------------------------------------------------------------------
module vp8_rtp_depacketizer_core_tb;

   // Parser positions within one packet.
   typedef enum logic [2:0] {
      ST_DESCRIPTOR,
      ST_EXTENSION,
      ST_PICTURE_ID_HI,
      ST_PICTURE_ID_LO,
      ST_TL0_INDEX,
      ST_TID_KEYIDX,
      ST_PAYLOAD
   } parse_state_type;

   // Bits of the set of optional descriptor fields still to be skipped.
   localparam int SKIP_PICTURE_ID = 0;
   localparam int SKIP_TL0_INDEX  = 1;
   localparam int SKIP_TID_KEYIDX = 2;

   localparam int QUIET_TAIL_WORDS = 80;
   localparam int RANDOM_WORDS     = 620;

   typedef logic [vp8d_pkg::ByteWidth-1:0] byte_list_type[$];

   typedef struct {
      logic [vp8d_pkg::ByteWidth-1:0] data_byte;
      logic                           first;
      logic                           last;
      logic                           marker;
      logic [vp8d_pkg::TsWidth-1:0]   stamp;
      bit                             hold;
   } packet_word_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [vp8d_pkg::ByteWidth-1:0] req_data_byte = '0;
   logic                           req_packet_first = 1'b0;
   logic                           req_packet_last = 1'b0;
   logic                           req_marker = 1'b0;
   logic [vp8d_pkg::TsWidth-1:0]   req_timestamp_ms = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [vp8d_pkg::ByteWidth-1:0] rsp_out_byte;
   logic                           rsp_byte_valid;
   logic                           rsp_start_of_gop;
   logic                           rsp_frame_end;
   logic                           rsp_frame_keyframe;
   logic [vp8d_pkg::TsWidth-1:0]   rsp_frame_timestamp;

   vp8_rtp_depacketizer_core uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data_byte       (req_data_byte),
      .req_packet_first    (req_packet_first),
      .req_packet_last     (req_packet_last),
      .req_marker          (req_marker),
      .req_timestamp_ms    (req_timestamp_ms),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_byte_valid      (rsp_byte_valid),
      .rsp_start_of_gop    (rsp_start_of_gop),
      .rsp_frame_end       (rsp_frame_end),
      .rsp_frame_keyframe  (rsp_frame_keyframe),
      .rsp_frame_timestamp (rsp_frame_timestamp)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Parser state of the predictor.
   parse_state_type                parse_state = ST_DESCRIPTOR;
   logic                           start_bit = 1'b0;
   logic [2:0]                     fields_to_skip = '0;
   logic                           payload_ahead = 1'b0;
   logic                           frame_is_key = 1'b0;
   logic [vp8d_pkg::TsWidth-1:0]   frame_stamp = '0;

   packet_word_type                pending_words[$];
   vp8d_pkg::result_type           expected_results[$];
   packet_word_type                next_word;
   vp8d_pkg::result_type           wanted;
   int unsigned                    issued_count = 0;
   int unsigned                    accepted_count = 0;
   int                             sender_gap = 0;
   int                             receiver_gap = 0;
   int                             idle_odds = 2;
   int                             error_count = 0;

   // Next parser position given the optional fields still to be skipped.
   function automatic parse_state_type state_after(input logic [2:0] skip);
      if (skip[SKIP_PICTURE_ID]) return ST_PICTURE_ID_HI;
      if (skip[SKIP_TL0_INDEX]) return ST_TL0_INDEX;
      if (skip[SKIP_TID_KEYIDX]) return ST_TID_KEYIDX;
      return ST_PAYLOAD;
   endfunction

   // Advance the descriptor parser by one accepted word and queue the result
   // that it causes, if any.
   task automatic predict_word(input logic [vp8d_pkg::ByteWidth-1:0] b,
                               input logic first,
                               input logic last, input logic mark,
                               input logic [vp8d_pkg::TsWidth-1:0] stamp);
      vp8d_pkg::result_type r;
      logic       payload;
      logic       gop;
      logic       closes;
      payload = 1'b0;
      gop = 1'b0;
      if (first) parse_state = ST_DESCRIPTOR;
      case (parse_state)
         ST_DESCRIPTOR: begin
            start_bit = b[vp8d_pkg::DescSBit];
            fields_to_skip = '0;
            payload_ahead = 1'b1;
            parse_state = b[vp8d_pkg::DescXBit] ? ST_EXTENSION : ST_PAYLOAD;
         end
         ST_EXTENSION: begin
            fields_to_skip = {b[vp8d_pkg::ExtTBit] | b[vp8d_pkg::ExtKBit],
                              b[vp8d_pkg::ExtLBit], b[vp8d_pkg::ExtIBit]};
            parse_state = state_after(fields_to_skip);
         end
         ST_PICTURE_ID_HI: begin
            if (b[vp8d_pkg::PicMBit]) begin
               parse_state = ST_PICTURE_ID_LO;
            end else begin
               fields_to_skip[SKIP_PICTURE_ID] = 1'b0;
               parse_state = state_after(fields_to_skip);
            end
         end
         ST_PICTURE_ID_LO: begin
            fields_to_skip[SKIP_PICTURE_ID] = 1'b0;
            parse_state = state_after(fields_to_skip);
         end
         ST_TL0_INDEX: begin
            fields_to_skip[SKIP_TL0_INDEX] = 1'b0;
            parse_state = state_after(fields_to_skip);
         end
         ST_TID_KEYIDX: begin
            fields_to_skip[SKIP_TID_KEYIDX] = 1'b0;
            parse_state = state_after(fields_to_skip);
         end
         default: begin
            payload = 1'b1;
            // The first payload byte of a partition start sets the frame up.
            if (payload_ahead) begin
               payload_ahead = 1'b0;
               if (start_bit) begin
                  frame_stamp = stamp;
                  if (!b[vp8d_pkg::PayloadPBit]) begin
                     frame_is_key = 1'b1;
                     gop = 1'b1;
                  end
               end
            end
         end
      endcase

      // A packet that ends inside its descriptor still captures the stamp if S is set.
      closes = last && mark;
      if (last) begin
         if (payload_ahead && start_bit) frame_stamp = stamp;
         payload_ahead = 1'b0;
         parse_state = ST_DESCRIPTOR;
      end

      if (payload || closes) begin
         r.out_byte = payload ? b : '0;
         r.byte_valid = payload;
         r.start_of_gop = gop;
         r.frame_end = closes;
         r.frame_keyframe = frame_is_key;
         r.frame_timestamp = frame_stamp;
         expected_results.push_back(r);
      end
      if (closes) begin
         frame_is_key = 1'b0;
         frame_stamp = '0;
      end
   endtask

   task automatic check_field(input string name,
                              input logic [vp8d_pkg::TsWidth-1:0] want,
                              input logic [vp8d_pkg::TsWidth-1:0] got);
      if (want !== got) begin
         error_count++;
         if (error_count <= 10)
            $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
      end
   endtask

   // Queue one packet of words; the flags break its framing on purpose.
   task automatic queue_packet(input byte_list_type bytes, input logic mark,
                               input logic [vp8d_pkg::TsWidth-1:0] stamp,
                               input bit drop_first,
                               input bit drop_last, input bit hold);
      packet_word_type w;
      for (int i = 0; i < bytes.size(); i++) begin
         w.data_byte = bytes[i];
         w.first = (i == 0) && !drop_first;
         w.last = (i == bytes.size() - 1) && !drop_last;
         w.marker = mark;
         w.stamp = stamp;
         w.hold = hold && (i == 0);
         pending_words.push_back(w);
      end
   endtask

   // Build a well-formed packet with random descriptor fields and payload,
   // then damage it now and then.
   task automatic queue_random_packet(input logic [vp8d_pkg::TsWidth-1:0] stamp,
                                      input logic mark);
      byte_list_type                    bytes;
      logic [vp8d_pkg::ByteWidth-1:0]   desc;
      logic [vp8d_pkg::ByteWidth-1:0]   ext;
      logic [vp8d_pkg::ByteWidth-1:0]   pic;
      int                               payload_count;
      int                               keep;
      desc = vp8d_pkg::ByteWidth'($urandom);
      bytes.push_back(desc);
      if (desc[vp8d_pkg::DescXBit]) begin
         ext = vp8d_pkg::ByteWidth'($urandom);
         bytes.push_back(ext);
         if (ext[vp8d_pkg::ExtIBit]) begin
            pic = vp8d_pkg::ByteWidth'($urandom);
            bytes.push_back(pic);
            if (pic[vp8d_pkg::PicMBit]) bytes.push_back(vp8d_pkg::ByteWidth'($urandom));
         end
         if (ext[vp8d_pkg::ExtLBit]) bytes.push_back(vp8d_pkg::ByteWidth'($urandom));
         if (ext[vp8d_pkg::ExtTBit] | ext[vp8d_pkg::ExtKBit])
            bytes.push_back(vp8d_pkg::ByteWidth'($urandom));
      end
      payload_count = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
      for (int i = 0; i < payload_count; i++) bytes.push_back(vp8d_pkg::ByteWidth'($urandom));
      if ($urandom_range(0, 7) == 0) begin
         keep = $urandom_range(1, bytes.size());
         while (bytes.size() > keep) void'(bytes.pop_back());
      end
      queue_packet(bytes, mark, stamp, $urandom_range(0, 9) == 0,
                   $urandom_range(0, 9) == 0, $urandom_range(0, 39) == 0);
   endtask

   // Sender: presents the next pending word once the previous one is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || accepted_count == issued_count) begin
         if (sender_gap > 0) begin
            sender_gap <= sender_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_words.size() == 0) begin
            req_valid <= 1'b0;
         end else if (pending_words[0].hold && expected_results.size() != 0) begin
            // Wait here until every outstanding result has come back.
            req_valid <= 1'b0;
         end else if (pending_words.size() > QUIET_TAIL_WORDS &&
                      $urandom_range(1, 12) <= idle_odds) begin
            sender_gap <= $urandom_range(0, 14);
            req_valid <= 1'b0;
         end else begin
            next_word = pending_words.pop_front();
            req_data_byte <= next_word.data_byte;
            req_packet_first <= next_word.first;
            req_packet_last <= next_word.last;
            req_marker <= next_word.marker;
            req_timestamp_ms <= next_word.stamp;
            req_valid <= 1'b1;
            issued_count <= issued_count + 1;
            if (issued_count[5:0] == 6'd0) idle_odds <= $urandom_range(0, 3);
         end
      end
   end

   // Receiver: stalls in random bursts, never in the tail of the run.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (receiver_gap > 0) begin
         receiver_gap <= receiver_gap - 1;
         rsp_ready <= 1'b0;
      end else if (pending_words.size() > QUIET_TAIL_WORDS &&
                   $urandom_range(1, 12) <= idle_odds) begin
         receiver_gap <= $urandom_range(0, 14);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor: checks results first, then predicts the word accepted now,
   // whose result can only appear at a later edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("%0t: unexpected result word, byte %h valid %b end %b",
                           $realtime, rsp_out_byte, rsp_byte_valid, rsp_frame_end);
            end else begin
               wanted = expected_results.pop_front();
               check_field("out_byte", vp8d_pkg::TsWidth'(wanted.out_byte),
                           vp8d_pkg::TsWidth'(rsp_out_byte));
               check_field("byte_valid", vp8d_pkg::TsWidth'(wanted.byte_valid),
                           vp8d_pkg::TsWidth'(rsp_byte_valid));
               check_field("start_of_gop", vp8d_pkg::TsWidth'(wanted.start_of_gop),
                           vp8d_pkg::TsWidth'(rsp_start_of_gop));
               check_field("frame_end", vp8d_pkg::TsWidth'(wanted.frame_end),
                           vp8d_pkg::TsWidth'(rsp_frame_end));
               check_field("frame_keyframe", vp8d_pkg::TsWidth'(wanted.frame_keyframe),
                           vp8d_pkg::TsWidth'(rsp_frame_keyframe));
               check_field("frame_timestamp", wanted.frame_timestamp,
                           rsp_frame_timestamp);
            end
         end
         if (req_valid && req_ready) begin
            predict_word(req_data_byte, req_packet_first, req_packet_last, req_marker,
                         req_timestamp_ms);
            accepted_count <= accepted_count + 1;
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      logic [vp8d_pkg::TsWidth-1:0] stamp;
      logic                         mark;
      packet_word_type              w;

      // Single descriptor byte with S set closes a frame with no payload.
      queue_packet('{8'h10}, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
      // Every extension field, two-byte picture id, keyframe payload.
      queue_packet('{8'h90, 8'hF0, 8'h80, 8'hFF, 8'h00, 8'h3F, 8'h00, 8'hFF},
                   1'b0, 32'h8000_0001, 1'b0, 1'b0, 1'b0);
      queue_packet('{8'h00, 8'hFE, 8'h01}, 1'b1, 32'h8000_0001, 1'b0, 1'b0, 1'b0);
      // Interframe start; the sender drains all results first.
      queue_packet('{8'h10, 8'h01}, 1'b1, 32'h0000_0000, 1'b0, 1'b0, 1'b1);
      // Extension cut short after a one-byte picture id.
      queue_packet('{8'h90, 8'hC0, 8'h05}, 1'b1, 32'h1234_5678, 1'b0, 1'b0, 1'b0);
      // Packet with no last word, cut off by a restart, then a marked packet.
      queue_packet('{8'h10, 8'h00, 8'h11}, 1'b0, 32'h0F0F_0F0F, 1'b0, 1'b1, 1'b0);
      queue_packet('{8'h00, 8'h77}, 1'b1, 32'h0F0F_0F0F, 1'b0, 1'b0, 1'b0);
      // Packet whose first word lacks its first flag.
      queue_packet('{8'h80, 8'h20, 8'h1F, 8'hAA}, 1'b1, 32'hF0F0_F0F0, 1'b1, 1'b0, 1'b0);

      // Random frames of packets, with some noise words between them.
      stamp = $urandom;
      while (pending_words.size() < RANDOM_WORDS) begin
         if ($urandom_range(0, 11) == 0) begin
            repeat ($urandom_range(1, 4)) begin
               w.data_byte = vp8d_pkg::ByteWidth'($urandom);
               w.first = 1'($urandom);
               w.last = 1'($urandom);
               w.marker = 1'($urandom);
               w.stamp = $urandom;
               w.hold = 1'b0;
               pending_words.push_back(w);
            end
         end
         mark = ($urandom_range(0, 2) == 0);
         queue_random_packet(stamp, mark);
         if (mark) begin
            case ($urandom_range(0, 9))
               0: stamp = '0;
               1: stamp = '1;
               default: stamp = $urandom;
            endcase
         end
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || accepted_count != issued_count ||
             expected_results.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Watchdog far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
